[hw/rtl/csd_pkg.sv]
// Shared types and constants for the chunk stream deframer.
// Holds record layout, status and route codes and register indexes.
// No dependencies.
package csd_pkg;

  // Chunk layout
  localparam int LEN_BYTES  = 4;
  localparam int TYPE_BYTES = 4;
  localparam int CRC_BYTES  = 4;

  // Bit that marks an ancillary chunk in the first type byte ('a' ^ 'A')
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Hook registers present in the register map
  localparam int HOOK_REGS = 4;

  // Defaults for top-level parameters
  localparam int DEF_NUM_HOOKS = 4;
  localparam int DEF_MAX_MAGIC = 8;

  // Entries in the queue between front and back
  localparam int QDEPTH = 4;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MAGIC     = 3'd0;
  localparam logic [2:0] CFG_MAGIC_LEN = 3'd1;
  localparam logic [2:0] CFG_HOOK0     = 3'd2;
  localparam logic [2:0] CFG_HOOK_EN   = 3'd6;

  typedef enum logic [1:0] {
    ST_CHUNK = 2'd0,
    ST_BADSIG = 2'd1,
    ST_TRUNC = 2'd2,
    ST_END   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RT_HOOK      = 2'd0,
    RT_ANCILLARY = 2'd1,
    RT_CRITICAL  = 2'd2
  } route_t;

  // One queued report from the front to the back
  typedef struct packed {
    status_t     status;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] data_offset;
    logic [31:0] stored_crc;
  } rec_t;

endpackage

[hw/rtl/csd_front.sv]
// Front end of the deframer: signature check and chunk header parsing.
// Takes one byte beat per cycle while take is high and pushes a report record to the queue.
// Depends on csd_pkg.
module csd_front
  import csd_pkg::*;
#(
  parameter int MAX_MAGIC = DEF_MAX_MAGIC
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic                   last,
  input  logic [7:0]             in_byte,
  input  logic [8*MAX_MAGIC-1:0] magic,
  input  logic [3:0]             sig_len,
  output logic                   push,
  output rec_t                   rec
);

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] ofs_r, ofs_nxt;
  logic [31:0] cnt_inc;
  logic [31:0] pos_inc;
  logic [7:0]  want;
  logic        sig_done;

  // Pick the expected signature byte for the current count
  always_comb begin
    want = '0;
    for (int i = 0; i < MAX_MAGIC; i++) begin
      if (cnt_r == 32'(i)) begin
        want = magic[8*i +: 8];
      end
    end
  end

  assign cnt_inc  = cnt_r + 32'd1;
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 32'd1;
  assign sig_done = cnt_r >= {28'd0, sig_len};

  // Classify the beat and advance the parser
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    ofs_nxt   = ofs_r;
    push      = 1'b0;
    rec       = '0;
    if (take) begin
      if (last) begin
        // End of stream: report (unless discarding after a bad signature) and rearm
        case (phase_r)
          PH_ERR: begin
            push = 1'b0;
          end
          PH_SIG: begin
            push       = 1'b1;
            rec.status = sig_done ? ST_END : ST_TRUNC;
          end
          PH_LEN: begin
            push       = 1'b1;
            rec.status = (cnt_r == '0) ? ST_END : ST_TRUNC;
          end
          default: begin
            push       = 1'b1;
            rec.status = ST_TRUNC;
          end
        endcase
        phase_nxt = PH_SIG;
        cnt_nxt   = '0;
        len_nxt   = '0;
        type_nxt  = '0;
        crc_nxt   = '0;
        pos_nxt   = '0;
        ofs_nxt   = '0;
      end else if (phase_r != PH_ERR) begin
        pos_nxt = pos_inc;
        case (phase_r)
          PH_SIG: begin
            if (!sig_done) begin
              if (in_byte != want) begin
                phase_nxt  = PH_ERR;
                cnt_nxt    = '0;
                push       = 1'b1;
                rec.status = ST_BADSIG;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end else begin
              // Signature complete: this beat is the first length byte
              len_nxt   = {len_r[23:0], in_byte};
              cnt_nxt   = 32'd1;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            len_nxt = {len_r[23:0], in_byte};
            if (cnt_inc == 32'(LEN_BYTES)) begin
              phase_nxt = PH_TYPE;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_TYPE: begin
            type_nxt = {type_r[23:0], in_byte};
            if (cnt_inc == 32'(TYPE_BYTES)) begin
              ofs_nxt   = pos_inc;
              phase_nxt = (len_r == '0) ? PH_CRC : PH_DATA;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_DATA: begin
            // Skip payload bytes
            if (cnt_inc == len_r) begin
              phase_nxt = PH_CRC;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_CRC: begin
            crc_nxt = {crc_r[23:0], in_byte};
            if (cnt_inc == 32'(CRC_BYTES)) begin
              push             = 1'b1;
              rec.status       = ST_CHUNK;
              rec.chunk_type   = type_r;
              rec.chunk_length = len_r;
              rec.data_offset  = ofs_r;
              rec.stored_crc   = {crc_r[23:0], in_byte};
              phase_nxt        = PH_LEN;
              cnt_nxt          = '0;
              len_nxt          = '0;
              type_nxt         = '0;
              crc_nxt          = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: begin
            phase_nxt = PH_ERR;
            cnt_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      cnt_r   <= '0;
      len_r   <= '0;
      type_r  <= '0;
      crc_r   <= '0;
      pos_r   <= '0;
      ofs_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      ofs_r   <= ofs_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An end beat always rearms the parser at the signature
  a_last_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> phase_r == PH_SIG && cnt_r == '0 && pos_r == '0)
    else $error("parser not rearmed after end beat");

  // After a bad signature, data beats give no report
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last && phase_r == PH_ERR |-> !push)
    else $error("report pushed while discarding after bad signature");
`endif

endmodule

[hw/rtl/csd_queue.sv]
// Short record queue between the parser front and the report back end.
// Register array with head and tail pointers and a fill count.
// Depends on csd_pkg.
module csd_queue
  import csd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic empty,
  output logic full
);

  localparam int QPW = $clog2(QDEPTH);

  rec_t           mem_r [QDEPTH];
  logic [QPW-1:0] wr_r, wr_nxt;
  logic [QPW-1:0] rd_r, rd_nxt;
  logic [QPW:0]   cnt_r, cnt_nxt;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == (QPW+1)'(QDEPTH);
  assign head  = mem_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = push ? wr_r + QPW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

`ifndef NO_ASSERTIONS
  // Never write into a full queue or read an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push |-> !full) and (pop |-> !empty))
    else $error("queue overrun or underrun");
`endif

endmodule

[hw/rtl/csd_back.sv]
// Back end of the deframer: hook matching, routing and the output register.
// Pops one record per free output slot.
// Depends on csd_pkg.
module csd_back
  import csd_pkg::*;
#(
  parameter int NUM_HOOKS = DEF_NUM_HOOKS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  rec_t                     q_head,
  output logic                     pop,
  input  logic [32*((NUM_HOOKS < HOOK_REGS) ? NUM_HOOKS : HOOK_REGS)-1:0] hook_types,
  input  logic [HOOK_REGS-1:0]     hook_en,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [135:0]             out_tdata,
  output logic [1:0]               out_tuser
);

  localparam int HOOK_N = (NUM_HOOKS < HOOK_REGS) ? NUM_HOOKS : HOOK_REGS;

  logic                 valid_r;
  rec_t                 rec_r;
  logic [HOOK_REGS-1:0] hits_r, hits;
  route_t               route_r, route;

  // Match the enabled hooks and choose a route
  always_comb begin
    hits  = '0;
    route = RT_HOOK;
    if (q_head.status == ST_CHUNK) begin
      for (int i = 0; i < HOOK_N; i++) begin
        hits[i] = hook_en[i] && (hook_types[32*i +: 32] == q_head.chunk_type);
      end
      if (hits != '0) begin
        route = RT_HOOK;
      end else if ((q_head.chunk_type[31:24] & CASE_BIT) != '0) begin
        route = RT_ANCILLARY;
      end else begin
        route = RT_CRITICAL;
      end
    end
  end

  // Load the output register whenever it is free or being taken
  assign pop = !q_empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r   <= q_head;
      hits_r  <= hits;
      route_r <= route;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rec_r.status;
  assign out_tdata  = {2'b00, route_r, hits_r, rec_r.stored_crc, rec_r.data_offset,
                       rec_r.chunk_length, rec_r.chunk_type};

`ifndef NO_ASSERTIONS
  // Status-only reports carry no hook hits and a zero route
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && rec_r.status != ST_CHUNK |-> hits_r == '0 && route_r == RT_HOOK)
    else $error("status report with hook or route bits set");
`endif

endmodule

[hw/rtl/chunk_stream_deframer_unit.sv]
// Top level of the chunk stream deframer: register file, front, queue, back.
// Depends on csd_pkg, csd_front, csd_queue, csd_back.
//
//   channel  dir  beat
//   in_      in   one file byte (tdata) or end of stream (tlast)
//   out_     out  one report: status in tuser, chunk fields in tdata
//   cfg_     in   one register write: index and data
//
// One byte beat is taken every cycle while the record queue is not full. The
// beat that completes a report pushes it into the four-entry record queue, which
// feeds the output register; the queue sets how long out_tready may stay low
// before in_tready drops. Reset is synchronous on rst_n and clears parser,
// queue and registers. Configuration writes are taken every cycle.
module chunk_stream_deframer_unit
  import csd_pkg::*;
#(
  parameter int NUM_HOOKS = DEF_NUM_HOOKS,
  parameter int MAX_MAGIC = DEF_MAX_MAGIC
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tlast,   // end of stream
  // Report stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [31:0] chunk_type, [63:32] chunk_length,
                                   // [95:64] data_offset, [127:96] stored_crc,
                                   // [131:128] hook_hits, [133:132] route
  output logic [1:0]   out_tuser,  // [1:0] status
  // Register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int HOOK_N = (NUM_HOOKS < HOOK_REGS) ? NUM_HOOKS : HOOK_REGS;

  logic [8*MAX_MAGIC-1:0] magic_r;
  logic [3:0]             magic_len_r;
  logic [32*HOOK_N-1:0]   hook_r;
  logic [HOOK_REGS-1:0]   hook_en_r;
  logic [3:0]             sig_len;
  logic                   take;
  logic                   push;
  rec_t                   push_rec;
  logic                   pop;
  rec_t                   q_head;
  logic                   q_empty;
  logic                   q_full;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= '0;
      magic_len_r <= '0;
      hook_r      <= '0;
      hook_en_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAGIC:     magic_r     <= cfg_data[8*MAX_MAGIC-1:0];
        CFG_MAGIC_LEN: magic_len_r <= cfg_data[3:0];
        CFG_HOOK_EN:   hook_en_r   <= cfg_data[HOOK_REGS-1:0];
        default: begin
          for (int i = 0; i < HOOK_N; i++) begin
            if (cfg_index == 3'(CFG_HOOK0 + 3'(i))) begin
              hook_r[32*i +: 32] <= cfg_data[31:0];
            end
          end
        end
      endcase
    end
  end

  // Clamp the signature length
  assign sig_len = (magic_len_r > 4'(MAX_MAGIC)) ? 4'(MAX_MAGIC) : magic_len_r;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  csd_front #(
    .MAX_MAGIC(MAX_MAGIC)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .last    (in_tlast),
    .in_byte (in_tdata),
    .magic   (magic_r),
    .sig_len (sig_len),
    .push    (push),
    .rec     (push_rec)
  );

  csd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  csd_back #(
    .NUM_HOOKS(NUM_HOOKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .hook_types (hook_r),
    .hook_en    (hook_en_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
